/* design/sik_pkg.sv */
// sik_pkg: widths, fixed angle constants, arctangent table and shared structs
// for the swerve inverse kinematics block; no dependencies
`timescale 1ns / 1ps
package sik_pkg;
	localparam int VEL_W      = 16;
	localparam int ANG_W      = 15;
	localparam int GEOM_W     = 12;
	localparam int DZ_W       = 15;
	localparam int PROD_W     = 29;
	localparam int WV_W       = 19;
	localparam int SQ_W       = 36;
	localparam int ROOT_W     = 18;
	localparam int REM_W      = 21;
	localparam int CW         = 40;
	localparam int ZW         = 26;
	localparam int SPD_W      = 18;
	localparam int MAG_W      = 17;
	localparam int ATAN_DEPTH = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam logic [1:0] REG_HALF_WHEELBASE = 2'd0;
	localparam logic [1:0] REG_HALF_TRACK     = 2'd1;
	localparam logic [1:0] REG_LIN_DZ         = 2'd2;
	localparam logic [1:0] REG_ANG_DZ         = 2'd3;

	localparam logic [1:0] WHEEL_FL = 2'd0;
	localparam logic [1:0] WHEEL_FR = 2'd1;
	localparam logic [1:0] WHEEL_RL = 2'd2;
	localparam logic [1:0] WHEEL_RR = 2'd3;

	localparam logic signed [ZW-1:0] F90  = 26'sd1474560;
	localparam logic signed [ZW-1:0] F180 = 26'sd2949120;
	localparam logic signed [ZW-1:0] F360 = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] ANG_MAX = 15'sd11520;
	localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;

	localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		26'sd737280, 26'sd435242, 26'sd229970, 26'sd116736,
		26'sd58595, 26'sd29326, 26'sd14667, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458,
		26'sd229, 26'sd115, 26'sd57, 26'sd29,
		26'sd14, 26'sd7, 26'sd4, 26'sd2,
		26'sd1, 26'sd0, 26'sd0, 26'sd0
	};

	typedef struct packed {
		logic [1:0]              idx;
		logic                    last;
		logic                    dead;
		logic signed [ANG_W-1:0] cur;
	} wheel_ctl_t;

	typedef struct packed {
		wheel_ctl_t           ctl;
		logic                 hspec;
		logic signed [ZW-1:0] hval;
	} head_side_t;
endpackage

/* design/sik_sequencer.sv */
// sik_sequencer: holds one command word and issues its four wheels in turn
// depends on sik_pkg
`timescale 1ns / 1ps
module sik_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [111:0]                    s_tdata,
	input  logic                            s_tuser,
	input  logic [sik_pkg::DZ_W-1:0]        lin_dz,
	input  logic [sik_pkg::DZ_W-1:0]        ang_dz,
	output logic                            issue_valid,
	output sik_pkg::wheel_ctl_t             issue_ctl,
	output logic signed [sik_pkg::VEL_W-1:0] vx,
	output logic signed [sik_pkg::VEL_W-1:0] vy,
	output logic signed [sik_pkg::VEL_W-1:0] yaw
);
	import sik_pkg::*;

	logic [107:0] data_q;
	logic         given_q;
	logic         busy_q;
	logic [1:0]   cnt_q;
	logic         take;
	logic         fire;
	logic signed [ANG_W-1:0] ang;
	logic [VEL_W:0] avx, avy, ayaw;

	function automatic logic [VEL_W:0] mag17(input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W:0] e;
		e = (VEL_W+1)'(v);
		return v[VEL_W-1] ? (VEL_W+1)'(-e) : (VEL_W+1)'(e);
	endfunction

	assign fire     = busy_q && en;
	assign s_tready = !busy_q || (fire && cnt_q == WHEEL_RR);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= WHEEL_FL;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= WHEEL_FL;
		end else if (fire) begin
			if (cnt_q == WHEEL_RR) busy_q <= 1'b0;
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q  <= s_tdata[107:0];
			given_q <= s_tuser;
		end
	end

	assign vx  = data_q[15:0];
	assign vy  = data_q[31:16];
	assign yaw = data_q[47:32];

	always_comb begin
		case (cnt_q)
			WHEEL_FL: ang = data_q[62:48];
			WHEEL_FR: ang = data_q[77:63];
			WHEEL_RL: ang = data_q[92:78];
			default:  ang = data_q[107:93];
		endcase
	end

	assign avx  = mag17(vx);
	assign avy  = mag17(vy);
	assign ayaw = mag17(yaw);

	assign issue_valid    = busy_q;
	assign issue_ctl.idx  = cnt_q;
	assign issue_ctl.last = (cnt_q == WHEEL_RR);
	assign issue_ctl.dead = (avx < (VEL_W+1)'(lin_dz)) && (avy < (VEL_W+1)'(lin_dz)) &&
		(ayaw < (VEL_W+1)'(ang_dz));
	assign issue_ctl.cur  = given_q ? ang : '0;
endmodule

/* design/sik_front.sv */
// sik_front: wheel velocity, squares and cordic set-up over three stages
// depends on sik_pkg
`timescale 1ns / 1ps
module sik_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  sik_pkg::wheel_ctl_t              in_ctl,
	input  logic signed [sik_pkg::VEL_W-1:0] vx,
	input  logic signed [sik_pkg::VEL_W-1:0] vy,
	input  logic signed [sik_pkg::VEL_W-1:0] yaw,
	input  logic [sik_pkg::GEOM_W-1:0]       half_wheelbase,
	input  logic [sik_pkg::GEOM_W-1:0]       half_track,
	output logic                             out_valid,
	output sik_pkg::head_side_t              out_side,
	output logic [sik_pkg::SQ_W-1:0]         sqx,
	output logic [sik_pkg::SQ_W-1:0]         sqy,
	output logic signed [sik_pkg::CW-1:0]    cx,
	output logic signed [sik_pkg::CW-1:0]    cy,
	output logic signed [sik_pkg::ZW-1:0]    cz
);
	import sik_pkg::*;

	logic signed [GEOM_W:0] rx, ry;
	logic v_s1, v_s2, v_s3;
	wheel_ctl_t ctl_s1, ctl_s2;
	logic signed [VEL_W-1:0] vx_s1, vy_s1;
	logic signed [PROD_W-1:0] prx_s1, pry_s1;
	logic signed [PROD_W-1:0] rnd_x, rnd_y;
	logic signed [WV_W-1:0] wvx_s2, wvy_s2;
	logic signed [2*WV_W-1:0] px, py;
	logic signed [CW-1:0] xs, ys;
	head_side_t side_s3;

	// rear wheels sit at -x, right wheels at -y
	assign rx = in_ctl.idx[1] ? -$signed({1'b0, half_wheelbase}) : $signed({1'b0, half_wheelbase});
	assign ry = in_ctl.idx[0] ? -$signed({1'b0, half_track}) : $signed({1'b0, half_track});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= in_ctl;
			vx_s1  <= vx;
			vy_s1  <= vy;
			prx_s1 <= PROD_W'(yaw) * PROD_W'(rx);
			pry_s1 <= PROD_W'(yaw) * PROD_W'(ry);
		end
	end

	assign rnd_x = (prx_s1 + PROD_W'(512)) >>> 10;
	assign rnd_y = (pry_s1 + PROD_W'(512)) >>> 10;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			wvx_s2 <= WV_W'(vx_s1) - rnd_y[WV_W-1:0];
			wvy_s2 <= WV_W'(vy_s1) + rnd_x[WV_W-1:0];
		end
	end

	assign px = (2*WV_W)'(wvx_s2) * (2*WV_W)'(wvx_s2);
	assign py = (2*WV_W)'(wvy_s2) * (2*WV_W)'(wvy_s2);
	assign xs = CW'(wvx_s2) <<< 16;
	assign ys = CW'(wvy_s2) <<< 16;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx <= px[SQ_W-1:0];
			sqy <= py[SQ_W-1:0];
			side_s3.ctl   <= ctl_s2;
			side_s3.hspec <= (wvx_s2 == '0) || (wvy_s2 == '0);
			if (wvy_s2 == '0)
				side_s3.hval <= (wvx_s2 < 0) ? F180 : '0;
			else
				side_s3.hval <= (wvy_s2 > 0) ? F90 : -F90;
			// left half plane: rotate by 180 first
			if (wvx_s2 < 0) begin
				cx <= -xs;
				cy <= -ys;
				cz <= (wvy_s2 > 0) ? F180 : -F180;
			end else begin
				cx <= xs;
				cy <= ys;
				cz <= '0;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
endmodule

/* design/sik_core.sv */
// sik_core: pipelined cordic vectoring and digit-by-digit square root side by side
// depends on sik_pkg
`timescale 1ns / 1ps
module sik_core #(
	parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sik_pkg::head_side_t           in_side,
	input  logic [sik_pkg::SQ_W-1:0]      sqx,
	input  logic [sik_pkg::SQ_W-1:0]      sqy,
	input  logic signed [sik_pkg::CW-1:0] cx,
	input  logic signed [sik_pkg::CW-1:0] cy,
	input  logic signed [sik_pkg::ZW-1:0] cz,
	output logic                          out_valid,
	output sik_pkg::head_side_t           out_side,
	output logic [sik_pkg::ROOT_W-1:0]    root,
	output logic signed [sik_pkg::ZW-1:0] z
);
	import sik_pkg::*;

	localparam int N = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;

	logic                 v_sc [N];
	head_side_t           side_sc [N];
	logic signed [CW-1:0] x_sc [N];
	logic signed [CW-1:0] y_sc [N];
	logic signed [ZW-1:0] z_sc [N];
	logic [REM_W-1:0]     r_sc [N];
	logic [ROOT_W-1:0]    q_sc [N];
	logic [SQ_W-1:0]      n_sc [N];

	for (genvar j = 0; j < N; j++) begin : g_st
		logic                 vp;
		head_side_t           sp;
		logic signed [CW-1:0] xp, yp, xn, yn;
		logic signed [ZW-1:0] zp, zn;
		logic [REM_W-1:0]     rp, rn;
		logic [ROOT_W-1:0]    qp, qn;
		logic [SQ_W-1:0]      np;

		if (j == 0) begin : g_in
			assign vp = in_valid;
			assign sp = in_side;
			assign xp = cx;
			assign yp = cy;
			assign zp = cz;
			assign rp = '0;
			assign qp = '0;
			assign np = sqx + sqy;
		end else begin : g_ch
			assign vp = v_sc[j-1];
			assign sp = side_sc[j-1];
			assign xp = x_sc[j-1];
			assign yp = y_sc[j-1];
			assign zp = z_sc[j-1];
			assign rp = r_sc[j-1];
			assign qp = q_sc[j-1];
			assign np = n_sc[j-1];
		end

		if (j < CORDIC_STAGES) begin : g_rot
			always_comb begin
				if (yp >= 0) begin
					xn = xp + (yp >>> j);
					yn = yp - (xp >>> j);
					zn = zp + ATAN_TAB[j];
				end else begin
					xn = xp - (yp >>> j);
					yn = yp + (xp >>> j);
					zn = zp - ATAN_TAB[j];
				end
			end
		end else begin : g_rot_pass
			assign xn = xp;
			assign yn = yp;
			assign zn = zp;
		end

		if (j < ROOT_W) begin : g_sqrt
			localparam int K = ROOT_W - 1 - j;
			logic [REM_W-1:0] rt, tt;
			assign rt = {rp[REM_W-3:0], np[2*K+1:2*K]};
			assign tt = REM_W'({qp, 2'b01});
			always_comb begin
				if (rt >= tt) begin
					rn = rt - tt;
					qn = {qp[ROOT_W-2:0], 1'b1};
				end else begin
					rn = rt;
					qn = {qp[ROOT_W-2:0], 1'b0};
				end
			end
		end else begin : g_sqrt_pass
			assign rn = rp;
			assign qn = qp;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sc[j] <= 1'b0;
			else if (en) v_sc[j] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sc[j] <= sp;
				x_sc[j]    <= xn;
				y_sc[j]    <= yn;
				z_sc[j]    <= zn;
				r_sc[j]    <= rn;
				q_sc[j]    <= qn;
				n_sc[j]    <= np;
			end
		end
	end

	assign out_valid = v_sc[N-1];
	assign out_side  = side_sc[N-1];
	assign root      = q_sc[N-1];
	assign z         = z_sc[N-1];
endmodule

/* design/sik_back.sv */
// sik_back: steering choice within a quarter turn, wraps, rounding and output register
// depends on sik_pkg
`timescale 1ns / 1ps
module sik_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sik_pkg::head_side_t           in_side,
	input  logic [sik_pkg::ROOT_W-1:0]    root,
	input  logic signed [sik_pkg::ZW-1:0] z,
	output logic                          out_valid,
	output logic [1:0]                    out_idx,
	output logic                          out_last,
	output logic signed [sik_pkg::SPD_W-1:0] out_speed,
	output logic signed [sik_pkg::ANG_W-1:0] out_angle
);
	import sik_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	wheel_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [MAG_W-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic signed [ZW-1:0] cf_s1, cf_s2, diff_s1, diff_s2, fin_s3, fin_s4;
	logic flip_s3, flip_s4;
	logic signed [ZW-1:0] head, cfine, d3, rnd;
	logic f3;
	logic signed [ANG_W-1:0] ang_o, cur_c;

	assign head  = in_side.hspec ? in_side.hval : z;
	assign cfine = ZW'(in_side.ctl.cur) <<< 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= in_side.ctl;
			cf_s1   <= cfine;
			diff_s1 <= head - cfine;
			mag_s1  <= root[ROOT_W-1] ? MAG_MAX : root[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			cf_s2  <= cf_s1;
			mag_s2 <= mag_s1;
			if (diff_s1 > F180)
				diff_s2 <= diff_s1 - F360;
			else if (diff_s1 <= -F180)
				diff_s2 <= diff_s1 + F360;
			else
				diff_s2 <= diff_s1;
		end
	end

	// beyond a quarter turn: steer the other way round and reverse the wheel
	always_comb begin
		if (diff_s2 > F90) begin
			d3 = diff_s2 - F180;
			f3 = 1'b1;
		end else if (diff_s2 < -F90) begin
			d3 = diff_s2 + F180;
			f3 = 1'b1;
		end else begin
			d3 = diff_s2;
			f3 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3  <= ctl_s2;
			mag_s3  <= mag_s2;
			fin_s3  <= cf_s2 + d3;
			flip_s3 <= f3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= ctl_s3;
			mag_s4 <= mag_s3;
			if (fin_s3 > F180) begin
				fin_s4  <= (fin_s3 - F180 > F180) ? F180 : fin_s3 - F180;
				flip_s4 <= !flip_s3;
			end else if (fin_s3 < -F180) begin
				fin_s4  <= (fin_s3 + F180 < -F180) ? -F180 : fin_s3 + F180;
				flip_s4 <= !flip_s3;
			end else begin
				fin_s4  <= fin_s3;
				flip_s4 <= flip_s3;
			end
		end
	end

	assign rnd = (fin_s4 + ZW'(128)) >>> 8;

	always_comb begin
		if (rnd > ZW'(ANG_MAX)) ang_o = ANG_MAX;
		else if (rnd < -ZW'(ANG_MAX)) ang_o = -ANG_MAX;
		else ang_o = rnd[ANG_W-1:0];
		if (ctl_s4.cur > ANG_MAX) cur_c = ANG_MAX;
		else if (ctl_s4.cur < -ANG_MAX) cur_c = -ANG_MAX;
		else cur_c = ctl_s4.cur;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx  <= ctl_s4.idx;
			out_last <= ctl_s4.last;
			if (ctl_s4.dead) begin
				out_speed <= '0;
				out_angle <= cur_c;
			end else begin
				out_speed <= flip_s4 ? -$signed({1'b0, mag_s4}) : $signed({1'b0, mag_s4});
				out_angle <= ang_o;
			end
		end
	end
endmodule

/* design/swerve_inverse_kinematics_unit.sv */
// swerve_inverse_kinematics_unit: top level, configuration registers and pipeline
// depends on sik_pkg, sik_sequencer, sik_front, sik_core, sik_back
`timescale 1ns / 1ps
// Each command word (vx, vy, yaw rate, four current steering angles) gives four wheel
// words, front left, front right, rear left, rear right, one per cycle while the pipeline
// is not stalled, the last with tlast set. The sequencer holds one command and feeds one
// wheel per cycle into a fully pipelined datapath, and takes the next command as the last
// wheel of the current one issues. The depth of the datapath is set by the longer of the
// square root (one result bit per stage) and the cordic (one rotation per stage). The
// pipeline only stalls while an output word waits for m_tready. Configuration writes
// are to be made only while the block is idle; the block itself does not enforce this.
module swerve_inverse_kinematics_unit #(
	parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // body_vx, body_vy, yaw_rate, angle_front_left,
	                               // angle_front_right, angle_rear_left, angle_rear_right
	input  logic         s_tuser,  // angles_given
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,  // wheel_speed, steer_angle
	output logic [1:0]   m_tuser,  // wheel_index
	output logic         m_tlast,  // last_wheel
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [14:0]  cfg_wdata
);
	import sik_pkg::*;

	logic [GEOM_W-1:0] half_wheelbase_q, half_track_q;
	logic [DZ_W-1:0]   lin_dz_q, ang_dz_q;
	logic              en;
	logic              iss_v, f_v, c_v;
	wheel_ctl_t        iss_ctl;
	logic signed [VEL_W-1:0] vx, vy, yaw;
	head_side_t        f_side, c_side;
	logic [SQ_W-1:0]   sqx, sqy;
	logic signed [CW-1:0] cx, cy;
	logic signed [ZW-1:0] cz, cz_out;
	logic [ROOT_W-1:0] root;
	logic signed [SPD_W-1:0] speed;
	logic signed [ANG_W-1:0] angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_wheelbase_q <= 12'd256;
			half_track_q     <= 12'd256;
			lin_dz_q         <= 15'd10;
			ang_dz_q         <= 15'd10;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HALF_WHEELBASE: half_wheelbase_q <= cfg_wdata[GEOM_W-1:0];
				REG_HALF_TRACK:     half_track_q     <= cfg_wdata[GEOM_W-1:0];
				REG_LIN_DZ:         lin_dz_q         <= cfg_wdata;
				REG_ANG_DZ:         ang_dz_q         <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	// whole pipeline moves unless the output word is held
	assign en = !m_tvalid || m_tready;

	sik_sequencer u_seq (
		.clk(clk), .arst_n(arst_n), .en(en),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.lin_dz(lin_dz_q), .ang_dz(ang_dz_q),
		.issue_valid(iss_v), .issue_ctl(iss_ctl), .vx(vx), .vy(vy), .yaw(yaw)
	);

	sik_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(iss_v), .in_ctl(iss_ctl), .vx(vx), .vy(vy), .yaw(yaw),
		.half_wheelbase(half_wheelbase_q), .half_track(half_track_q),
		.out_valid(f_v), .out_side(f_side), .sqx(sqx), .sqy(sqy),
		.cx(cx), .cy(cy), .cz(cz)
	);

	sik_core #(.CORDIC_STAGES(CORDIC_STAGES)) u_core (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_v), .in_side(f_side), .sqx(sqx), .sqy(sqy),
		.cx(cx), .cy(cy), .cz(cz),
		.out_valid(c_v), .out_side(c_side), .root(root), .z(cz_out)
	);

	sik_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(c_v), .in_side(c_side), .root(root), .z(cz_out),
		.out_valid(m_tvalid), .out_idx(m_tuser), .out_last(m_tlast),
		.out_speed(speed), .out_angle(angle)
	);

	assign m_tdata = {7'b0, angle, speed};
endmodule

/* dv/swerve_inverse_kinematics_unit_test.sv */
// testbench for swerve_inverse_kinematics_unit: drives body velocity commands, predicts the
// four wheel words of each one and checks them in order; depends on sik_pkg and the block
`timescale 1ns / 1ps

class wheel_scoreboard;
	logic [1:0]  exp_idx[$];
	logic [17:0] exp_speed[$];
	logic [14:0] exp_angle[$];
	logic        exp_last[$];
	int          errors;
	int          checked;

	function void note_command(logic [111:0] d, logic given, logic [11:0] hw, logic [11:0] ht,
			logic [14:0] lin_dz, logic [14:0] ang_dz);
		longint vx, vy, yaw, cur, rx, ry, wvx, wvy, mag, cf, diff, fin, spd, ang;
		logic flip, dead;
		vx = longint'($signed(d[15:0]));
		vy = longint'($signed(d[31:16]));
		yaw = longint'($signed(d[47:32]));
		dead = (abs_of(vx) < lin_dz) && (abs_of(vy) < lin_dz) && (abs_of(yaw) < ang_dz);
		for (int w = 0; w < 4; w++) begin
			cur = given ? longint'($signed(d[48 + 15*w +: 15])) : 0;
			spd = 0;
			if (dead) begin
				ang = clamp_angle(cur);
			end else begin
				rx = (w < 2) ? longint'(hw) : -longint'(hw);
				ry = (w & 1) ? -longint'(ht) : longint'(ht);
				wvx = vx - fshift(yaw * ry + 512, 10);
				wvy = vy + fshift(yaw * rx + 512, 10);
				mag = root_of(wvx * wvx + wvy * wvy);
				if (mag > 131071) mag = 131071;
				flip = 0;
				cf = cur * 256;
				diff = bearing(wvx, wvy) - cf;
				while (diff > 2949120) diff -= 5898240;
				while (diff <= -2949120) diff += 5898240;
				if (diff > 1474560) begin
					diff -= 2949120; flip = ~flip;
				end else if (diff < -1474560) begin
					diff += 2949120; flip = ~flip;
				end
				fin = cf + diff;
				if (fin > 2949120) begin
					fin -= 2949120; flip = ~flip;
				end else if (fin < -2949120) begin
					fin += 2949120; flip = ~flip;
				end
				if (fin > 2949120) fin = 2949120;
				if (fin < -2949120) fin = -2949120;
				spd = flip ? -mag : mag;
				ang = clamp_angle(fshift(fin + 128, 8));
			end
			exp_idx.push_back(w[1:0]);
			exp_speed.push_back(spd[17:0]);
			exp_angle.push_back(ang[14:0]);
			exp_last.push_back(w == 3);
		end
	endfunction

	static function longint abs_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	static function longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint clamp_angle(longint a);
		if (a > 11520) return 11520;
		if (a < -11520) return -11520;
		return a;
	endfunction

	static function longint root_of(longint n);
		longint r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - r - b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	static function longint bearing(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		if (y == 0) return x < 0 ? 2949120 : 0;
		if (x == 0) return y > 0 ? 1474560 : -1474560;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			z = y > 0 ? 2949120 : -2949120;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < sik_pkg::CORDIC_STAGES_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += sik_pkg::ATAN_TAB[i];
			end else begin
				x -= ys; y += xs; z -= sik_pkg::ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	task check_wheel(logic [1:0] idx, logic [17:0] spd, logic [14:0] ang, logic last);
		if (exp_idx.size() == 0) begin
			report_fault("wheel word with nothing expected");
			return;
		end
		checked++;
		if (idx !== exp_idx[0] || spd !== exp_speed[0] || ang !== exp_angle[0]
				|| last !== exp_last[0])
			report_fault($sformatf("got idx %0d speed %0d angle %0d last %0d, want %0d %0d %0d %0d",
				idx, $signed(spd), $signed(ang), last, exp_idx[0], $signed(exp_speed[0]),
				$signed(exp_angle[0]), exp_last[0]));
		void'(exp_idx.pop_front());
		void'(exp_speed.pop_front());
		void'(exp_angle.pop_front());
		void'(exp_last.pop_front());
	endtask

	task report_fault(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask
endclass

module swerve_inverse_kinematics_unit_test;
	import sik_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_idx = '0;
	logic [14:0]  cfg_wdata = '0;

	logic [11:0] geom_wb = 12'd256, geom_tr = 12'd256;
	logic [14:0] dz_lin = 15'd10, dz_ang = 15'd10;
	bit          calm = 0;
	int          commands = 0;
	longint      cycles = 0;
	wheel_scoreboard board;

	swerve_inverse_kinematics_unit dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver with random stall bursts
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 9);
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_wheel(m_tuser, m_tdata[17:0], m_tdata[32:18], m_tlast);

	task automatic write_reg(logic [1:0] idx, logic [14:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HALF_WHEELBASE: geom_wb = val[11:0];
			REG_HALF_TRACK:     geom_tr = val[11:0];
			REG_LIN_DZ:         dz_lin = val;
			default:            dz_ang = val;
		endcase
	endtask

	task automatic drain;
		while (board.exp_idx.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// valid stays up between back to back words and drops for idle bursts and after each run
	task automatic send_command(logic signed [15:0] vx, logic signed [15:0] vy,
			logic signed [15:0] yaw, logic signed [14:0] a0, logic signed [14:0] a1,
			logic signed [14:0] a2, logic signed [14:0] a3, logic given);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			n = $urandom_range(1, 9);
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, a3, a2, a1, a0, yaw, vy, vx};
		s_tuser <= given;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_command({4'b0, a3, a2, a1, a0, yaw, vy, vx}, given, geom_wb, geom_tr,
			dz_lin, dz_ang);
		commands++;
	endtask

	function automatic logic signed [14:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 15'sd11520;
			1: return -15'sd11520;
			2: return 15'($urandom);
			default: return 15'($signed($urandom_range(0, 23040)) - 11520);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_commands(int count);
		for (int i = 0; i < count; i++)
			send_command(rand_vel(), rand_vel(), rand_vel(), rand_angle(), rand_angle(),
				rand_angle(), rand_angle(), $urandom_range(0, 3) != 0);
	endtask

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: deadzone, axes, cardinal headings, flips and saturation
		send_command(16'sd0, 16'sd0, 16'sd0, 15'sd100, -15'sd200, 15'sd11520, -15'sd11520,
			1'b1);
		send_command(16'sd5, -16'sd5, 16'sd3, 15'sd300, 15'sd0, 15'sd0, 15'sd0, 1'b0);
		send_command(16'sd2000, 16'sd0, 16'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1);
		send_command(-16'sd2000, 16'sd0, 16'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1);
		send_command(16'sd0, 16'sd2000, 16'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1);
		send_command(16'sd0, -16'sd2000, 16'sd0, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1);
		send_command(16'sd0, 16'sd0, 16'sd3000, 15'sd0, 15'sd0, 15'sd0, 15'sd0, 1'b1);
		send_command(16'sd1000, 16'sd1000, -16'sd1000, 15'sd11520, -15'sd11520,
			15'sd5760, -15'sd5760, 1'b1);
		send_command(16'sh7fff, 16'sh7fff, 16'sh7fff, 15'sh3fff, 15'sh4000, 15'sd0, 15'sd0,
			1'b1);
		send_command(16'sh8000, 16'sh8000, 16'sh8000, 15'sh7fff, 15'sh7fff, 15'sh7fff,
			15'sh7fff, 1'b1);
		send_command(-16'sd700, 16'sd50, 16'sd0, 15'sd11000, -15'sd11000, 15'sd8000,
			-15'sd3000, 1'b1);
		s_tvalid <= 1'b0;
		drain();

		write_reg(REG_HALF_WHEELBASE, 15'h7fff);
		write_reg(REG_HALF_TRACK, 15'h0fff);
		write_reg(REG_LIN_DZ, 15'h7fff);
		write_reg(REG_ANG_DZ, 15'h7fff);
		random_commands(40);
		s_tvalid <= 1'b0;
		drain();

		write_reg(REG_HALF_WHEELBASE, 15'd0);
		write_reg(REG_HALF_TRACK, 15'd0);
		write_reg(REG_LIN_DZ, 15'd0);
		write_reg(REG_ANG_DZ, 15'd0);
		random_commands(60);
		s_tvalid <= 1'b0;
		drain();

		write_reg(REG_HALF_WHEELBASE, 15'($urandom_range(0, 4095)));
		write_reg(REG_HALF_TRACK, 15'($urandom_range(0, 4095)));
		write_reg(REG_LIN_DZ, 15'($urandom_range(0, 64)));
		write_reg(REG_ANG_DZ, 15'($urandom_range(0, 64)));
		random_commands(60);
		calm = 1;
		random_commands(40);
		s_tvalid <= 1'b0;

		while (board.exp_idx.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("ran %0d commands over several geometries and deadzones, %0d wheel words checked",
			commands, board.checked);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
